// ===== sv/egbw_pkg.sv =====
// Shared types and constants for the Exp-Golomb bit writer.
`timescale 1ns / 1ps
`default_nettype none

package egbw_pkg;

  // Request type codes as they arrive on the input channel.
  localparam logic [2:0] REQ_RAW   = 3'd0;
  localparam logic [2:0] REQ_UEG   = 3'd1;
  localparam logic [2:0] REQ_SEG   = 3'd2;
  localparam logic [2:0] REQ_FLAG  = 3'd3;
  localparam logic [2:0] REQ_ALIGN = 3'd4;
  localparam logic [2:0] REQ_FLUSH = 3'd5;

  // Packing window: up to seven held bits plus a code of up to 65 bits.
  localparam int unsigned WIN_W = 72;

  // What the packer has to do with a coded request.
  typedef enum logic [1:0] {
    K_BITS,
    K_ALIGN,
    K_FLUSH
  } kind_t;

  // A request reduced to a right-aligned bit string and its length.
  typedef struct packed {
    kind_t       kind;
    logic [32:0] w;
    logic [6:0]  len;
    logic        err;
  } code_t;

endpackage

`default_nettype wire

// ===== sv/egbw_coder.sv =====
// Request coder: maps each request to a bit string and its length over three stages.
`timescale 1ns / 1ps
`default_nettype none

module egbw_coder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_req_type,
  input  wire logic [31:0]         in_code_value,
  input  wire logic [5:0]          in_code_length,
  input  wire logic signed [31:0]  in_signed_value,
  output logic                     code_valid,
  input  wire logic                code_take,
  output egbw_pkg::code_t          code
);
  import egbw_pkg::*;

  // Index of the highest set bit.
  function automatic logic [5:0] msb_idx(input logic [32:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  // Stage 1: captured request.
  logic        v1_r;
  logic [2:0]  typ_r;
  logic [31:0] val_r;
  logic [5:0]  len_r;
  logic [31:0] sv_r;

  // Stage 2: mapped code value; stage 3: final code with its length.
  logic        v2_r;
  code_t       c2_r;
  code_t       c2_nxt;
  logic        eg2_r;
  logic        eg2_nxt;
  logic        v3_r;
  code_t       c3_r;
  code_t       c3_nxt;

  logic        s1_rdy;
  logic        s2_rdy;
  logic        s3_rdy;
  logic [5:0]  raw_len;
  logic [31:0] raw_mask;
  logic [31:0] raw_bits;
  logic [31:0] sv_neg;

  assign s3_rdy     = !v3_r || code_take;
  assign s2_rdy     = !v2_r || s3_rdy;
  assign s1_rdy     = !v1_r || s2_rdy;
  assign in_stall   = !s1_rdy;
  assign code_valid = v3_r;
  assign code       = c3_r;

  // Stage 1 to 2: turn the request into a value whose bits are to be written.
  always_comb begin
    raw_len  = (len_r > 6'd32) ? 6'd32 : len_r;
    raw_mask = (raw_len == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << raw_len[4:0]) - 32'd1);
    raw_bits = val_r & raw_mask;
    sv_neg   = (~sv_r) + 32'd1;
    c2_nxt   = '{kind: K_BITS, w: 33'd0, len: 7'd0, err: 1'b0};
    eg2_nxt  = 1'b0;
    case (typ_r)
      REQ_RAW: begin
        c2_nxt.w   = {1'b0, raw_bits};
        c2_nxt.len = {1'b0, raw_len};
        c2_nxt.err = (raw_bits != val_r);
      end
      REQ_UEG: begin
        c2_nxt.w   = {1'b0, val_r} + 33'd1;
        c2_nxt.err = (val_r == 32'hFFFF_FFFF);
        eg2_nxt    = 1'b1;
      end
      REQ_SEG: begin
        // Zero and negative values map to -2v, so the code value plus one is odd.
        if (sv_r[31] || (sv_r == 32'd0)) begin
          c2_nxt.w = {sv_neg, 1'b1};
        end else begin
          c2_nxt.w = {sv_r, 1'b0};
        end
        eg2_nxt = 1'b1;
      end
      REQ_FLAG: begin
        c2_nxt.w   = {32'd0, val_r[0]};
        c2_nxt.len = 7'd1;
      end
      REQ_ALIGN: c2_nxt.kind = K_ALIGN;
      REQ_FLUSH: c2_nxt.kind = K_FLUSH;
      default: ;
    endcase
  end

  // Stage 2 to 3: an Exp-Golomb code is w in a field of twice its top bit index plus one.
  always_comb begin
    c3_nxt = c2_r;
    if (eg2_r) begin
      c3_nxt.len = {msb_idx(c2_r.w), 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (s1_rdy) v1_r <= in_valid;
      if (s2_rdy) v2_r <= v1_r;
      if (s3_rdy) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      typ_r <= in_req_type;
      val_r <= in_code_value;
      len_r <= in_code_length;
      sv_r  <= in_signed_value;
    end
    if (s2_rdy && v1_r) begin
      c2_r  <= c2_nxt;
      eg2_r <= eg2_nxt;
    end
    if (s3_rdy && v2_r) begin
      c3_r <= c3_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/exp_golomb_bit_writer_top.sv =====
// Top level of the Exp-Golomb bit writer: bit packing, byte buffer and result register.
//
//   Channel   Handshake           Payload
//   in        in_valid/in_stall   in_req_type, in_code_value, in_code_length, in_signed_value
//   out       out_valid/out_stall out_byte, out_byte_partial, out_byte_valid,
//                                 out_total_bytes, out_input_error, out_last_result
//
// A request completing n bytes (up to nine) holds the packer while the byte buffer drains them,
// one byte per cycle while the output does not stall; one yielding at most one result does not.
// A request passes the coder stages, the byte buffer and the result register on its way to the port.
// Reset is synchronous and clears the pipeline, the held bits and the byte count.
// A stall on the output holds the result register and backs up through the buffer to in_stall.
`timescale 1ns / 1ps
`default_nettype none

module exp_golomb_bit_writer_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [31:0]        in_code_value,
  input  wire logic [5:0]         in_code_length,
  input  wire logic signed [31:0] in_signed_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_byte_partial,
  output logic                    out_byte_valid,
  output logic [31:0]             out_total_bytes,
  output logic                    out_input_error,
  output logic                    out_last_result
);
  import egbw_pkg::*;

  logic        code_valid;
  logic        code_take;
  code_t       code;

  // Writer state: held bits sit at the top of held_r, the rest are zero.
  logic [2:0]  cnt_r;
  logic [7:0]  held_r;
  logic [31:0] bytes_r;

  // Byte buffer between the packer and the result register.
  logic [WIN_W-1:0] p_win_r;
  logic [3:0]       p_cnt_r;
  logic             p_err_r;
  logic             p_partial_r;
  logic             p_bvalid_r;
  logic [31:0]      p_total_r;

  logic             o_v_r;

  logic [6:0]       pk_len;
  logic [6:0]       pk_tot;
  logic [6:0]       pk_sh;
  logic [WIN_W-1:0] pk_win;
  logic [WIN_W-1:0] pk_rest;
  logic [3:0]       pk_nb;
  logic [3:0]       pk_nres;
  logic             pk_held;
  logic             out_load;
  logic             p_free;
  logic             p_load;

  egbw_coder u_coder (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_code_value   (in_code_value),
    .in_code_length  (in_code_length),
    .in_signed_value (in_signed_value),
    .code_valid      (code_valid),
    .code_take       (code_take),
    .code            (code)
  );

  always_comb begin
    pk_held = (cnt_r != 3'd0);
    if (code.kind == K_ALIGN) begin
      pk_len = pk_held ? (7'd8 - {4'd0, cnt_r}) : 7'd0;
    end else begin
      pk_len = code.len;
    end
    pk_tot  = {4'd0, cnt_r} + pk_len;
    pk_sh   = 7'(WIN_W) - pk_tot;
    pk_win  = {held_r, 64'd0} | ({39'd0, code.w} << pk_sh);
    pk_nb   = pk_tot[6:3];
    pk_rest = pk_win << {pk_nb, 3'b000};
    if (code.kind == K_FLUSH) begin
      pk_nres = 4'd1;
    end else if (pk_nb == 4'd0 && code.err) begin
      pk_nres = 4'd1;
    end else begin
      pk_nres = pk_nb;
    end
  end

  assign out_load  = (p_cnt_r != 4'd0) && (!o_v_r || !out_stall);
  assign p_free    = (p_cnt_r == 4'd0) || (p_cnt_r == 4'd1 && out_load);
  // A request that yields no result may pass the packer while the buffer still drains.
  assign code_take = code_valid && (p_free || pk_nres == 4'd0);
  assign p_load    = code_take && (pk_nres != 4'd0);
  assign out_valid = o_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      held_r  <= 8'd0;
      bytes_r <= 32'd0;
      p_cnt_r <= 4'd0;
      o_v_r   <= 1'b0;
    end else begin
      if (code_take) begin
        cnt_r   <= pk_tot[2:0];
        held_r  <= pk_rest[WIN_W-1 -: 8];
        bytes_r <= bytes_r + {28'd0, pk_nb};
      end
      if (p_load) begin
        p_cnt_r <= pk_nres;
      end else if (out_load) begin
        p_cnt_r <= p_cnt_r - 4'd1;
      end
      if (out_load) begin
        o_v_r <= 1'b1;
      end else if (!out_stall) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_win_r <= pk_win;
      p_err_r <= code.err;
      if (code.kind == K_FLUSH) begin
        p_partial_r <= pk_held;
        p_bvalid_r  <= pk_held;
        p_total_r   <= bytes_r + {31'd0, pk_held};
      end else begin
        p_partial_r <= 1'b0;
        p_bvalid_r  <= (pk_nb != 4'd0);
        p_total_r   <= 32'd0;
      end
    end else if (out_load) begin
      p_win_r <= p_win_r << 8;
    end
    if (out_load) begin
      out_byte         <= p_bvalid_r ? p_win_r[WIN_W-1 -: 8] : 8'd0;
      out_byte_partial <= p_partial_r;
      out_byte_valid   <= p_bvalid_r;
      out_total_bytes  <= p_total_r;
      out_input_error  <= p_err_r;
      out_last_result  <= (p_cnt_r == 4'd1);
    end
  end

  a_buf_depth : assert property (@(posedge clk) disable iff (!rst_n)
    p_cnt_r <= 4'd9)
    else $error("byte buffer count beyond nine");

  a_held_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (held_r & (8'hFF >> cnt_r)) == 8'd0)
    else $error("held bits below the fill point are not zero");

  a_count_only : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0 && !out_byte_partial)
    else $error("count-only result carries a byte");

  a_partial_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_partial |-> out_last_result && out_byte_valid)
    else $error("partial byte not the final result of a flush");

  a_total_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_bytes != 32'd0 |-> out_last_result)
    else $error("byte count shown on a result that is not final");

endmodule

`default_nettype wire
